[rtl/core/tccs_pkg.sv]
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console with cursor and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  // fixed field widths of the item ports
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 16;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // character and cell constants
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, BLANK_CHAR};

  // controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the input item
    logic exec;      // carry out the request
    logic fill;      // write one blank cell and step the fill counters
    logic init;      // fill with the power-on blank cell
    logic load_out;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_fill;  // request needs a row fill or a screen fill
    logic fill_last;  // current fill write is the last one
    logic out_busy;   // output register holds an item not taken this cycle
  } ctrl_status_t;

endpackage

`default_nettype wire

[rtl/core/text_console_cursor_scroll.sv]
// Flow: an accepted item is latched, executed and its result loaded into the
//   output register; a scroll adds a fill of one row, a clear a screen fill.
// Items: one at a time; a new item is accepted only once the last result is
//   loaded into the output register, which waits while the output stalls.
// Fills use the single memory write port. Reset: a power-on clear fills the
//   screen with blank light-grey cells; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console with a character screen, a cursor, wrap, newline and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ATTR_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CELL_W-1:0]      cell_data_o,
  output logic [ROW_W-1:0]       cursor_row_out_o,
  output logic [COL_W-1:0]       cursor_col_out_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  // sequencer
  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // screen, cursor and output register
  tccs_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_data_o      (cell_data_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o)
  );

endmodule

`default_nettype wire

[rtl/core/tccs_ctrl.sv]
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer of the console: power-on clear, request execution, fills and
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl
  import tccs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire ctrl_status_t st_i,
  output ctrl_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_FILL = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill = 1'b1;
        cmd_o.init = 1'b1;
        if (st_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = st_i.need_fill ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (st_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tccs_dpath.sv]
// ----------------------------------------------------------------------------
// tccs_dpath
// Datapath of the console: screen memory addressed through a circular row
// base, cursor, colour register, fill counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_dpath
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  output ctrl_status_t           st_o,
  input  wire logic              cfg_we_i,
  input  wire logic [ATTR_W-1:0] cfg_wdata_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CELL_W-1:0]      cell_data_o,
  output logic [ROW_W-1:0]       cursor_row_out_o,
  output logic [COL_W-1:0]       cursor_col_out_o
);

  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = ROWS * (1 << CW);

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
  localparam logic [7:0]    ROW_LIM  = 8'(ROWS);
  localparam logic [7:0]    COL_LIM  = 8'(COLUMNS);

  // logical row to physical row through the rotating base
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[RW-1:0];
  endfunction

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [RW-1:0]     base_q, base_d;
  logic [ATTR_W-1:0] color_q;
  logic [RW-1:0]     fill_row_q, fill_row_d;
  logic [CW-1:0]     fill_col_q, fill_col_d;
  logic              fill_one_q, fill_one_d;
  logic              out_valid_q;

  logic [REQ_W-1:0]  req_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [COL_W-1:0]  rd_col_q;

  logic [CELL_W-1:0] cell_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  logic              is_put, is_nl, row_adv, row_end, scroll, read_hit;
  logic              mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, fill_cell;

  // request decode and status
  always_comb begin
    is_put   = (req_q == REQ_PUT);
    is_nl    = (char_q == NEWLINE_CHAR);
    row_adv  = is_nl || (cur_col_q == COL_LAST);
    row_end  = (cur_row_q == ROW_LAST);
    scroll   = is_put && row_adv && row_end;
    read_hit = ({3'b000, rd_row_q} < ROW_LIM) && ({1'b0, rd_col_q} < COL_LIM);

    st_o.need_fill = scroll || (req_q == REQ_CLEAR);
    st_o.fill_last = (fill_col_q == COL_LAST) && (fill_one_q || (fill_row_q == ROW_LAST));
    st_o.out_busy  = out_valid_q && !out_ready_i;
  end

  // memory port selection
  always_comb begin
    fill_cell = cmd_i.init ? RESET_CELL : {color_q, BLANK_CHAR};
    mem_we    = cmd_i.fill || (cmd_i.exec && is_put && !is_nl);
    waddr     = cmd_i.fill ? {fill_row_q, fill_col_q}
                           : {phys_row(cur_row_q, base_q), cur_col_q};
    wdata     = cmd_i.fill ? fill_cell : {color_q, char_q};
    mem_re    = cmd_i.exec && (req_q == REQ_READ) && read_hit;
    raddr     = {phys_row(RW'(rd_row_q), base_q), CW'(rd_col_q)};
  end

  // cursor, scroll base and fill counters
  always_comb begin
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    base_d     = base_q;
    fill_row_d = fill_row_q;
    fill_col_d = fill_col_q;
    fill_one_d = fill_one_q;
    if (cmd_i.exec) begin
      if (is_put) begin
        if (!row_adv) begin
          cur_col_d = cur_col_q + CW'(1);
        end else begin
          cur_col_d = '0;
          if (row_end) begin
            // scroll: the oldest physical row becomes the new last row
            base_d     = (base_q == ROW_LAST) ? '0 : base_q + RW'(1);
            fill_row_d = base_q;
            fill_col_d = '0;
            fill_one_d = 1'b1;
          end else begin
            cur_row_d = cur_row_q + RW'(1);
          end
        end
      end else if (req_q == REQ_CLEAR) begin
        fill_row_d = '0;
        fill_col_d = '0;
        fill_one_d = 1'b0;
      end
    end
    if (cmd_i.fill) begin
      if (fill_col_q == COL_LAST) begin
        fill_col_d = '0;
        fill_row_d = (fill_row_q == ROW_LAST) ? '0 : fill_row_q + RW'(1);
      end else begin
        fill_col_d = fill_col_q + CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      base_q      <= '0;
      color_q     <= RESET_ATTR;
      fill_row_q  <= '0;
      fill_col_q  <= '0;
      fill_one_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      base_q     <= base_d;
      fill_row_q <= fill_row_d;
      fill_col_q <= fill_col_d;
      fill_one_q <= fill_one_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_type_i;
      char_q   <= char_code_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cell_q    <= ((req_q == REQ_READ) && read_hit) ? rdata_q : '0;
      out_row_q <= ROW_W'(cur_row_q);
      out_col_q <= COL_W'(cur_col_q);
    end
  end

  // screen memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_data_o      = cell_q;
  assign cursor_row_out_o = out_row_q;
  assign cursor_col_out_o = out_col_q;

endmodule

`default_nettype wire

[rtl/core/tccs_checker.sv]
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_checker
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CELL_W-1:0] cell_data_o,
  input wire logic [ROW_W-1:0]  cursor_row_out_o,
  input wire logic [COL_W-1:0]  cursor_col_out_o
);

  localparam logic [7:0] ROW_LIM = 8'(ROWS);
  localparam logic [7:0] COL_LIM = 8'(COLUMNS);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // one item in work at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // every result belongs to an accepted item
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 2'd0))
    else $error("result delivered without a pending item");

  // at most the working item and the waiting result are in flight
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more items in flight than stages");

  // cursor shown is always on the screen (row not checked for over 32 rows)
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({3'b000, cursor_row_out_o} < ROW_LIM) || (ROWS > 32))
                    && ({1'b0, cursor_col_out_o} < COL_LIM))
    else $error("cursor outside the screen");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_data_o)
                                    && $stable(cursor_row_out_o)
                                    && $stable(cursor_col_out_o))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .cell_data_o      (cell_data_o),
  .cursor_row_out_o (cursor_row_out_o),
  .cursor_col_out_o (cursor_col_out_o)
);

`default_nettype wire
